// ----- hdl/tlcu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Truncated linear convolution unit: shared package
// Default sizes, field widths, operation and register codes, sequencer
// states and the control word that travels down the multiply pipeline.
// ----------------------------------------------------------------------------
package tlcu_pkg;

    localparam int DEF_MAX_LEN     = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int LEN_W     = 6;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_RUN         = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_LENGTH  = 2'd0,
        CFG_SECOND_LENGTH = 2'd1,
        CFG_OUTPUT_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_term;
        logic [POS_W-1:0] pos;
        logic             run_last;
    } t_mac_ctl;

endpackage : tlcu_pkg
`default_nettype wire

// ----- hdl/truncated_linear_convolution_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Truncated linear convolution unit
// Loads two signed sample sequences and streams their truncated full
// linear convolution, one exact sum per output.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0 or 1) writes one sample into the first or
// second store and is taken every cycle. A run transaction (tuser 2) emits
// the first min(output_limit, first_length + second_length - 1) outputs of
// the convolution, each tagged with its position and tlast on the final
// one; a limit of zero emits nothing. During a run the input is not ready.
// Each output n reads one store pair and does one multiply-accumulate per
// cycle, one for each of its terms, then drains the two-stage multiply
// pipeline. Finished results wait in an output register, so the
// next transaction can be taken while the last result is still pending.
// Store entries that were never written read back as unknown data.
// ----------------------------------------------------------------------------
module truncated_linear_convolution_unit
    import tlcu_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // index, sample
    input  wire logic [((IDX_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // position, value
    output logic [((POS_W + 2 * SAMPLE_BITS + $clog2(MAX_LEN) + 7) / 8) * 8 - 1:0]
                                       m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [LEN_W-1:0]      i_cfg_data
);

    localparam int AW      = $clog2(MAX_LEN);
    localparam int VALUE_W = 2 * SAMPLE_BITS + AW;
    localparam int OUT_W   = ((POS_W + VALUE_W + 7) / 8) * 8;

    logic                   we_first, we_second, re, taken;
    logic [AW-1:0]          waddr, raddr_first, raddr_second;
    logic [SAMPLE_BITS-1:0] rdata_first, rdata_second, wdata;
    t_mac_ctl               ctl;
    logic [POS_W-1:0]       out_pos;
    logic [VALUE_W-1:0]     out_value;

    assign wdata = s_axis_tdata[IDX_W +: SAMPLE_BITS];

    tlcu_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_index        (s_axis_tdata[IDX_W-1:0]),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_taken        (taken),
        .o_we_first     (we_first),
        .o_we_second    (we_second),
        .o_waddr        (waddr),
        .o_re           (re),
        .o_raddr_first  (raddr_first),
        .o_raddr_second (raddr_second),
        .o_ctl          (ctl)
    );

    tlcu_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LEN)
    ) u_first_store (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr_first),
        .o_rdata (rdata_first)
    );

    tlcu_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LEN)
    ) u_second_store (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr_second),
        .o_rdata (rdata_second)
    );

    tlcu_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .VALUE_W     (VALUE_W)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_a         (rdata_first),
        .i_b         (rdata_second),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_pos       (out_pos),
        .o_value     (out_value),
        .o_last      (m_axis_tlast),
        .o_taken     (taken)
    );

    assign m_axis_tdata = OUT_W'({out_value, out_pos});

endmodule : truncated_linear_convolution_unit
`default_nettype wire

// ----- hdl/tlcu_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlcu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : tlcu_ram
`default_nettype wire

// ----- hdl/tlcu_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer
// Holds the configuration registers, decodes input transactions into store
// writes, and walks a run's (output, term) pairs, one read pair a cycle in S_MAC.
// ----------------------------------------------------------------------------
module tlcu_seq
    import tlcu_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [OP_W-1:0]              i_op,
    input  wire logic [IDX_W-1:0]             i_index,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [LEN_W-1:0]             i_cfg_data,
    input  wire logic                         i_taken,
    output logic                              o_we_first,
    output logic                              o_we_second,
    output logic [$clog2(MAX_LEN)-1:0]        o_waddr,
    output logic                              o_re,
    output logic [$clog2(MAX_LEN)-1:0]        o_raddr_first,
    output logic [$clog2(MAX_LEN)-1:0]        o_raddr_second,
    output t_mac_ctl                          o_ctl
);

    localparam int AW = $clog2(MAX_LEN);
    localparam logic [8:0] MAX_LEN_V = 9'(MAX_LEN);

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_first_length, r_second_length, r_output_limit;
    logic [LEN_W-1:0] r_len1, n_len1, r_len2, n_len2;
    logic [POS_W-1:0] r_count, n_count, r_n, n_n;
    logic [LEN_W-1:0] r_k, n_k, r_kmax, n_kmax;
    logic             r_first, n_first;

    logic             in_acc;
    logic             idx_ok;
    logic [LEN_W-1:0] len1_c, len2_c;
    logic [LEN_W:0]   full;
    logic [POS_W-1:0] run_count;
    logic             run_last;

    // Saturate a length register into the range one to MAX_LEN.
    function automatic logic [LEN_W-1:0] f_clamp(input logic [LEN_W-1:0] len);
        logic [8:0] wide;
        wide = 9'(len);
        if (len == '0) begin
            return LEN_W'(1);
        end
        if (wide > MAX_LEN_V) begin
            return LEN_W'(MAX_LEN_V);
        end
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] f_kmin(input logic [POS_W-1:0] n,
                                               input logic [LEN_W-1:0] len2);
        logic [LEN_W-1:0] top;
        top = len2 - LEN_W'(1);
        return (n >= top) ? (n - top) : '0;
    endfunction

    function automatic logic [LEN_W-1:0] f_kmax(input logic [POS_W-1:0] n,
                                               input logic [LEN_W-1:0] len1);
        logic [LEN_W-1:0] top;
        top = len1 - LEN_W'(1);
        return (n < top) ? n : top;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign idx_ok      = (9'(i_index) < MAX_LEN_V);

    assign o_we_first  = in_acc && idx_ok && (t_op'(i_op) == OP_LOAD_FIRST);
    assign o_we_second = in_acc && idx_ok && (t_op'(i_op) == OP_LOAD_SECOND);
    assign o_waddr     = AW'(i_index);

    assign len1_c    = f_clamp(r_first_length);
    assign len2_c    = f_clamp(r_second_length);
    assign full      = (LEN_W+1)'(len1_c) + (LEN_W+1)'(len2_c) - (LEN_W+1)'(1);
    assign run_count = ((LEN_W+1)'(r_output_limit) < full) ? r_output_limit
                                                           : POS_W'(full);
    assign run_last  = ((r_n + POS_W'(1)) == r_count);

    assign o_re           = (r_state == S_MAC);
    assign o_raddr_first  = AW'(r_k);
    assign o_raddr_second = AW'(r_n - r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_first_length  <= LEN_W'(1);
            r_second_length <= LEN_W'(1);
            r_output_limit  <= LEN_W'(63);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FIRST_LENGTH:  r_first_length  <= i_cfg_data;
                    CFG_SECOND_LENGTH: r_second_length <= i_cfg_data;
                    CFG_OUTPUT_LIMIT:  r_output_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len1  <= n_len1;
        r_len2  <= n_len2;
        r_count <= n_count;
        r_n     <= n_n;
        r_k     <= n_k;
        r_kmax  <= n_kmax;
        r_first <= n_first;
    end

    always_comb begin
        n_state = r_state;
        n_len1  = r_len1;
        n_len2  = r_len2;
        n_count = r_count;
        n_n     = r_n;
        n_k     = r_k;
        n_kmax  = r_kmax;
        n_first = r_first;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (t_op'(i_op) == OP_RUN) && (run_count != '0)) begin
                    n_state = S_MAC;
                    n_len1  = len1_c;
                    n_len2  = len2_c;
                    n_count = run_count;
                    n_n     = '0;
                    n_k     = '0;
                    n_kmax  = '0;
                    n_first = 1'b1;
                end
            end
            S_MAC: begin
                o_ctl.valid     = 1'b1;
                o_ctl.first     = r_first;
                o_ctl.last_term = (r_k == r_kmax);
                o_ctl.pos       = r_n;
                o_ctl.run_last  = run_last;
                n_k             = r_k + LEN_W'(1);
                n_first         = 1'b0;
                if (r_k == r_kmax) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait until the finished sum has moved to the output register.
                if (i_taken) begin
                    if (run_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_n     = r_n + POS_W'(1);
                        n_k     = f_kmin(n_n, r_len2);
                        n_kmax  = f_kmax(n_n, r_len1);
                        n_first = 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule : tlcu_seq
`default_nettype wire

// ----- hdl/tlcu_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply-accumulate datapath
// Registered product of the two store reads, a full-precision accumulator
// and the output register of the result stream.
// ----------------------------------------------------------------------------
module tlcu_mac
    import tlcu_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int VALUE_W     = 2 * DEF_SAMPLE_BITS + 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_mac_ctl               i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_a,
    input  wire logic [SAMPLE_BITS-1:0] i_b,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [POS_W-1:0]            o_pos,
    output logic [VALUE_W-1:0]          o_value,
    output logic                        o_last,
    output logic                        o_taken
);

    localparam int PW = 2 * SAMPLE_BITS;

    t_mac_ctl                   r_c1, r_c2;
    logic signed [PW-1:0]       r_prod;
    logic signed [VALUE_W-1:0]  r_acc;
    logic                       r_done;
    logic [POS_W-1:0]           r_pos;
    logic                       r_end;
    logic                       r_ovalid;
    logic signed [VALUE_W-1:0]  prod_ext;

    assign prod_ext = VALUE_W'(r_prod);
    assign o_taken  = r_done && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1     <= '0;
            r_c2     <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_c1 <= i_ctl;
            r_c2 <= r_c1;
            if (r_c2.valid && r_c2.last_term) begin
                r_done <= 1'b1;
            end else if (o_taken) begin
                r_done <= 1'b0;
            end
            if (o_taken) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c1.valid) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
        if (r_c2.valid) begin
            r_acc <= (r_c2.first ? '0 : r_acc) + prod_ext;
            if (r_c2.last_term) begin
                r_pos <= r_c2.pos;
                r_end <= r_c2.run_last;
            end
        end
        if (o_taken) begin
            o_value <= r_acc;
            o_pos   <= r_pos;
            o_last  <= r_end;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule : tlcu_mac
`default_nettype wire

// ----- hdl/tlcu_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the truncated linear convolution unit
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module tlcu_chk
    import tlcu_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [OP_W-1:0]       s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [((POS_W + 2 * SAMPLE_BITS + $clog2(MAX_LEN) + 7) / 8) * 8 - 1:0]
                                      m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    // A stalled result transaction keeps its payload.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Loads never stall the input side.
    a_load_no_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_RUN) |=> s_axis_tready)
        else $error("input stalled after a load");

    // Reset leaves the block idle with no pending result.
    a_reset_state : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule : tlcu_chk

bind truncated_linear_convolution_unit tlcu_chk #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_tlcu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
